>>> rtl/plti_pkg.sv
// Shared types and constants for the piecewise-linear table interpolation unit.
// No dependencies; used by plti_div and the top level.
`default_nettype none

package plti_pkg;

  // word field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 24;
  localparam int SCALE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = KEY_W + SCALE_W;
  // scale delta times key delta
  localparam int PROD_W   = SCALE_W + KEY_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABOVE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BELOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ORDER = 3'd5;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [KEY_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/plti_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module plti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/plti_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on plti_pkg for the request and response structs.
`default_nettype none

module plti_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire plti_pkg::div_req_t req,
  output plti_pkg::div_rsp_t     rsp
);

  import plti_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [KEY_W-1:0]  divisor_r, divisor_nxt;
  logic [KEY_W-1:0]  rem_r, rem_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [KEY_W:0]    trial;
  logic              fits;

  // one shift-subtract step
  always_comb begin
    trial       = {rem_r, quo_r[PROD_W-1]};
    fits        = trial >= {1'b0, divisor_r};
    divisor_nxt = divisor_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    if (req.start) begin
      divisor_nxt = req.divisor;
      rem_nxt     = '0;
      quo_nxt     = req.dividend;
      cnt_nxt     = '0;
      busy_nxt    = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? KEY_W'(trial - {1'b0, divisor_r}) : trial[KEY_W-1:0];
      quo_nxt = {quo_r[PROD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    divisor_r <= divisor_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

>>> rtl/piecewise_linear_table_interp_unit.sv
// Top level of the piecewise-linear table interpolation unit.
// Depends on plti_pkg, plti_ram and plti_div.
// Keeps up to TABLE_DEPTH (redshift, scale) points in non-decreasing key order
// in one RAM and answers queries by linear interpolation between the bracketing
// pair, truncating the fractional step toward zero. Every word in gives one word
// out. Append, clear, unused commands and queries on an empty table or above
// the last point are answered from S_IDLE into the result register. A query
// reads entry 0 in S_FIRST, then scans on in S_SCAN, one entry per cycle, to
// the upper bracketing point; unless the pair has equal keys it multiplies in
// S_MUL, starts the serial divider in S_DST and waits in S_DIV. Below-range
// and single-point queries go from S_FIRST to S_DONE. One word is in work at
// a time; a new word is taken only when the result register is empty or is
// read in the same cycle, so a stalled result holds off the input.
`default_nettype none

module piecewise_linear_table_interp_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [plti_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [plti_pkg::KEY_W-1:0]      in_key_redshift,
  input  wire logic [plti_pkg::SCALE_W-1:0]    in_point_scale_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [plti_pkg::SCALE_W-1:0]    out_scale_out,
  output logic      [plti_pkg::STATUS_W-1:0]   out_status
);

  import plti_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] IDX_ONE = {{(AW-1){1'b0}}, 1'b1};
  localparam logic [CW-1:0] CNT_ONE = {{AW{1'b0}}, 1'b1};

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_SCAN, S_MUL, S_DST, S_DIV, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [KEY_W-1:0]  last_key_r, last_key_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [KEY_W-1:0]  prev_key_r, prev_key_nxt;
  logic [SCALE_W-1:0] prev_scale_r, prev_scale_nxt;
  logic [KEY_W-1:0]  dr_r, dr_nxt;
  logic [KEY_W-1:0]  dz_r, dz_nxt;
  logic [SCALE_W-1:0] mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SCALE_W-1:0] res_scale_r, res_scale_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SCALE_W-1:0] out_scale_r, out_scale_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic              accept;
  logic              out_free;
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [SCALE_W-1:0] rd_scale;
  logic [SCALE_W-1:0] q_scale;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign rd_key   = ram_rdata[ENTRY_W-1:SCALE_W];
  assign rd_scale = ram_rdata[SCALE_W-1:0];
  assign q_scale  = div_rsp.quotient[SCALE_W-1:0];

  // point table: key in the upper bits, scale in the lower
  plti_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata({in_key_redshift, in_point_scale_in}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // serial divider for the interpolation step
  assign div_req.start    = (state_r == S_DST);
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = dr_r;

  plti_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // read address: entry 0 on entry, then one ahead of the scan
  always_comb begin
    case (state_r)
      S_FIRST: ram_raddr = IDX_ONE;
      S_SCAN:  ram_raddr = idx_r + IDX_ONE;
      default: ram_raddr = '0;
    endcase
  end

  // command decode, table scan and result sequencing
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    last_key_nxt   = last_key_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    prev_key_nxt   = prev_key_r;
    prev_scale_nxt = prev_scale_r;
    dr_nxt         = dr_r;
    dz_nxt         = dz_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    prod_nxt       = prod_r;
    res_scale_nxt  = res_scale_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_scale_nxt  = out_scale_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_scale_nxt  = '0;
          out_status_nxt = ST_OK;
          key_nxt        = in_key_redshift;
          case (in_cmd)
            CMD_APPEND: begin
              if (count_r == CW'(TABLE_DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else if (count_r != '0 && in_key_redshift < last_key_r) begin
                out_status_nxt = ST_ORDER;
              end else begin
                ram_we       = 1'b1;
                count_nxt    = count_r + CNT_ONE;
                last_key_nxt = in_key_redshift;
              end
            end
            CMD_QUERY: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (in_key_redshift > last_key_r) begin
                out_status_nxt = ST_ABOVE;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_FIRST;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end

      // entry 0 is on the read port
      S_FIRST: begin
        prev_key_nxt   = rd_key;
        prev_scale_nxt = rd_scale;
        idx_nxt        = IDX_ONE;
        res_scale_nxt  = rd_scale;
        if (key_r < rd_key) begin
          res_status_nxt = ST_BELOW;
          state_nxt      = S_DONE;
        end else if (count_r == CNT_ONE) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      // entry idx_r is on the read port, idx_r + 1 is being read
      S_SCAN: begin
        res_status_nxt = ST_OK;
        if (key_r <= rd_key || {1'b0, idx_r} == count_r - CNT_ONE) begin
          if (rd_key <= prev_key_r) begin
            res_scale_nxt = rd_scale;
            state_nxt     = S_DONE;
          end else begin
            dr_nxt    = rd_key - prev_key_r;
            dz_nxt    = key_r - prev_key_r;
            neg_nxt   = rd_scale < prev_scale_r;
            mag_nxt   = (rd_scale < prev_scale_r) ? prev_scale_r - rd_scale
                                                  : rd_scale - prev_scale_r;
            state_nxt = S_MUL;
          end
        end else begin
          prev_key_nxt   = rd_key;
          prev_scale_nxt = rd_scale;
          idx_nxt        = idx_r + IDX_ONE;
        end
      end

      S_MUL: begin
        prod_nxt  = PROD_W'(mag_r) * PROD_W'(dz_r);
        state_nxt = S_DST;
      end

      S_DST: begin
        state_nxt = S_DIV;
      end

      // apply the truncated step to the lower scale
      S_DIV: begin
        if (div_rsp.done) begin
          res_scale_nxt = neg_r ? prev_scale_r - q_scale : prev_scale_r + q_scale;
          state_nxt     = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_scale_nxt  = res_scale_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_key_r   <= last_key_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    prev_key_r   <= prev_key_nxt;
    prev_scale_r <= prev_scale_nxt;
    dr_r         <= dr_nxt;
    dz_r         <= dz_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    prod_r       <= prod_nxt;
    res_scale_r  <= res_scale_nxt;
    res_status_r <= res_status_nxt;
    out_scale_r  <= out_scale_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_scale_out = out_scale_r;
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for piecewise_linear_table_interp_unit: directed and random words
// checked against a local model of the point table. Depends on plti_pkg and the unit's RTL.
`timescale 1ns / 100ps

module testbench;
  import plti_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 950;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [KEY_W-1:0] KEY_MAX = 24'hFFFFFF;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic [SCALE_W-1:0] scale;
    bit                 hold;  // wait for all results before sending
  } word_t;

  typedef struct {
    logic [SCALE_W-1:0]  scale;
    logic [STATUS_W-1:0] status;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [KEY_W-1:0] in_key_redshift = '0;
  logic [SCALE_W-1:0] in_point_scale_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SCALE_W-1:0] out_scale_out;
  logic [STATUS_W-1:0] out_status;

  piecewise_linear_table_interp_unit #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_key_redshift(in_key_redshift),
    .in_point_scale_in(in_point_scale_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_scale_out(out_scale_out),
    .out_status(out_status)
  );

  // words waiting to be sent, and results owed by the unit
  word_t word_feed[$];
  answer_t owed_results[$];

  // predicted table contents
  logic [KEY_W-1:0] lut_key[TABLE_DEPTH];
  logic [SCALE_W-1:0] lut_scale[TABLE_DEPTH];
  int lut_count = 0;

  // keys the stimulus generator expects to be in the table
  logic [KEY_W-1:0] plan_key[TABLE_DEPTH];
  int plan_count = 0;
  int planned_words = 0;

  int mismatches = 0;
  int results_seen = 0;
  int queries_sent = 0;
  int status_tally[8];
  int cycle_count = 0;

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // linear step between two points, truncated toward zero
  function automatic logic [SCALE_W-1:0] interp_scale(
      input logic [KEY_W-1:0] r0, input logic [SCALE_W-1:0] s0,
      input logic [KEY_W-1:0] r1, input logic [SCALE_W-1:0] s1,
      input logic [KEY_W-1:0] key);
    logic [63:0] span;
    logic [63:0] dz;
    logic [63:0] mag;
    logic [63:0] q;
    if (r1 <= r0) return s1;
    span = 64'(r1) - 64'(r0);
    dz = 64'(key) - 64'(r0);
    if (s1 >= s0) begin
      mag = 64'(s1) - 64'(s0);
      q = (mag * dz) / span;
      return s0 + q[SCALE_W-1:0];
    end
    mag = 64'(s0) - 64'(s1);
    q = (mag * dz) / span;
    return s0 - q[SCALE_W-1:0];
  endfunction

  // update the predicted table and queue the result the word should give
  task automatic apply_word(input word_t w);
    answer_t a;
    int i;
    a.scale = '0;
    a.status = ST_OK;
    case (w.cmd)
      CMD_APPEND: begin
        if (lut_count >= TABLE_DEPTH) begin
          a.status = ST_FULL;
        end else if (lut_count > 0 && w.key < lut_key[lut_count-1]) begin
          a.status = ST_ORDER;
        end else begin
          lut_key[lut_count] = w.key;
          lut_scale[lut_count] = w.scale;
          lut_count++;
        end
      end
      CMD_QUERY: begin
        queries_sent++;
        if (lut_count == 0) begin
          a.status = ST_EMPTY;
        end else if (w.key > lut_key[lut_count-1]) begin
          a.status = ST_ABOVE;
        end else if (w.key < lut_key[0]) begin
          a.scale = lut_scale[0];
          a.status = ST_BELOW;
        end else if (lut_count == 1) begin
          a.scale = lut_scale[0];
        end else begin
          // first point at or above the key is the upper end
          i = 1;
          while (i < lut_count - 1 && w.key > lut_key[i]) i++;
          a.scale = interp_scale(lut_key[i-1], lut_scale[i-1], lut_key[i], lut_scale[i], w.key);
        end
      end
      CMD_CLEAR: begin
        lut_count = 0;
      end
      default: begin
      end
    endcase
    status_tally[a.status]++;
    owed_results.insert(owed_results.size(), a);
  endtask

  // queue one word and track what the table will hold
  task automatic add_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                          input logic [SCALE_W-1:0] scale, input bit hold);
    word_t w;
    w.cmd = cmd;
    w.key = key;
    w.scale = scale;
    w.hold = hold;
    word_feed.insert(word_feed.size(), w);
    if (cmd != CMD_UNUSED) planned_words++;
    if (cmd == CMD_CLEAR) plan_count = 0;
    if (cmd == CMD_APPEND && plan_count < TABLE_DEPTH &&
        (plan_count == 0 || key >= plan_key[plan_count-1])) begin
      plan_key[plan_count] = key;
      plan_count++;
    end
  endtask

  // query: 0 inside the table, 1 on a point, 2 below, 3 above
  task automatic add_query(input int kind);
    logic [KEY_W-1:0] first;
    logic [KEY_W-1:0] last;
    logic [KEY_W-1:0] key;
    if (plan_count == 0) begin
      add_word(CMD_QUERY, KEY_W'($urandom), $urandom, 1'b0);
      return;
    end
    first = plan_key[0];
    last = plan_key[plan_count-1];
    case (kind)
      1: key = plan_key[$urandom_range(0, plan_count - 1)];
      2: key = (first == 0) ? first : KEY_W'($urandom_range(0, first - 1));
      3: key = (last == KEY_MAX) ? last : KEY_W'($urandom_range(last + 1, KEY_MAX));
      default: key = first + KEY_W'($urandom_range(0, last - first));
    endcase
    add_word(CMD_QUERY, key, $urandom, 1'b0);
  endtask

  // stimulus, then reset, then wait for the run to drain
  initial begin
    int seq;
    int npts;
    int nq;
    int j;
    int lo;
    int step_max;
    int key;
    int pick;

    // directed: every command, field extremes, special cases
    add_word(CMD_QUERY, 24'h000000, 32'h00000000, 1'b0);   // empty table
    add_word(CMD_UNUSED, KEY_MAX, 32'hFFFFFFFF, 1'b0);
    add_word(CMD_APPEND, 24'h000100, 32'h00010000, 1'b0);
    add_word(CMD_QUERY, 24'h000100, 32'hFFFFFFFF, 1'b0);   // single point, on it
    add_word(CMD_QUERY, 24'h000000, 32'h00000000, 1'b0);   // below, clamped
    add_word(CMD_QUERY, 24'h000101, 32'h00000000, 1'b0);   // above
    add_word(CMD_APPEND, 24'h0000FF, 32'h12345678, 1'b0);  // out of order
    add_word(CMD_APPEND, 24'h000100, 32'hFFFFFFFF, 1'b0);  // equal key accepted
    add_word(CMD_QUERY, 24'h000100, 32'h00000000, 1'b0);   // zero-width interval
    add_word(CMD_APPEND, KEY_MAX, 32'h00000000, 1'b0);     // falling scale
    add_word(CMD_QUERY, 24'h800000, 32'h00000000, 1'b0);
    add_word(CMD_QUERY, KEY_MAX, 32'h00000000, 1'b0);
    add_word(CMD_APPEND, KEY_MAX, 32'h12345678, 1'b0);
    add_word(CMD_QUERY, 24'hFFFFFE, 32'h00000000, 1'b0);
    add_word(CMD_CLEAR, KEY_MAX, 32'hFFFFFFFF, 1'b0);
    add_word(CMD_QUERY, 24'h000100, 32'h00000000, 1'b0);   // empty after clear
    add_word(CMD_APPEND, 24'h000000, 32'h00000000, 1'b0);
    add_word(CMD_QUERY, 24'h000000, 32'h00000000, 1'b0);   // equal to first point
    add_word(CMD_APPEND, KEY_MAX, 32'hFFFFFFFF, 1'b0);
    add_word(CMD_QUERY, 24'h7FFFFF, 32'h00000000, 1'b0);
    add_word(CMD_QUERY, 24'h000001, 32'h00000000, 1'b0);
    add_word(CMD_QUERY, 24'hFFFFFE, 32'h00000000, 1'b0);

    // random tables: clear, sorted appends mixed with queries and noise, then queries
    planned_words = 0;
    seq = 0;
    while (planned_words < RANDOM_WORDS) begin
      add_word(CMD_CLEAR, KEY_W'($urandom), $urandom, (seq == 0) || ($urandom_range(0, 5) == 0));
      if ($urandom_range(0, 5) == 0) add_query($urandom_range(0, 3));
      npts = (seq == 0 || $urandom_range(0, 15) == 0) ? TABLE_DEPTH : $urandom_range(1, 10);
      lo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 24'hF00000);
      step_max = (KEY_MAX - lo) / npts;
      key = lo;
      for (j = 0; j < npts; j++) begin
        add_word(CMD_APPEND, KEY_W'(key), $urandom, 1'b0);
        pick = $urandom_range(0, 19);
        if (pick < 5) add_query($urandom_range(0, 3));
        else if (pick < 7 && key > 0) add_word(CMD_APPEND, KEY_W'($urandom_range(0, key - 1)),
                                               $urandom, 1'b0);
        else if (pick == 7) add_word(CMD_UNUSED, KEY_W'($urandom), $urandom, 1'b0);
        if ($urandom_range(0, 7) != 0 && step_max > 0) key += $urandom_range(1, step_max);
        if (key > KEY_MAX) key = KEY_MAX;
      end
      // appends into a full table
      if (npts == TABLE_DEPTH) begin
        add_word(CMD_APPEND, KEY_MAX, $urandom, 1'b0);
        add_word(CMD_APPEND, KEY_W'($urandom), $urandom, 1'b0);
      end
      nq = $urandom_range(4, 20);
      for (j = 0; j < nq; j++) begin
        pick = $urandom_range(0, 9);
        add_query(pick < 6 ? 0 : pick < 8 ? 1 : pick - 6);
      end
      seq++;
    end

    // reset, once
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (!(word_feed.size() == 0 && !in_valid && owed_results.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      mismatches++;
    end
    $display("checked %0d result words, %0d queries: %0d ok, %0d above, %0d below, %0d empty",
             results_seen, queries_sent, status_tally[ST_OK], status_tally[ST_ABOVE],
             status_tally[ST_BELOW], status_tally[ST_EMPTY]);
    $display("appends refused: %0d on a full table, %0d out of order",
             status_tally[ST_FULL], status_tally[ST_ORDER]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // driver: presents queued words with random gaps
  word_t cur_word;
  int send_gap = 0;
  bit send_sparse = 1'b1;
  bit send_slot;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      send_slot = !in_valid;
      if (in_valid && !in_stall) begin
        apply_word(cur_word);
        send_slot = 1'b1;
      end
      if (send_slot) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (word_feed.size() > 0 && !(word_feed[0].hold && owed_results.size() > 0)) begin
          cur_word = word_feed.pop_front();
          in_valid <= 1'b1;
          in_cmd <= cur_word.cmd;
          in_key_redshift <= cur_word.key;
          in_point_scale_in <= cur_word.scale;
          if ($urandom_range(0, 63) == 0) send_sparse = !send_sparse;
          send_gap = send_sparse ? $urandom_range(0, 6) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stalls, each result word checked against the oldest prediction
  answer_t want;
  int stall_left = 0;
  bit recv_sparse = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result word: scale_out %h status %0d", out_scale_out, out_status);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          results_seen++;
          if (out_scale_out !== want.scale) begin
            $error("scale_out: expected %h, actual %h", want.scale, out_scale_out);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            mismatches++;
          end
        end
        if ($urandom_range(0, 63) == 0) recv_sparse = !recv_sparse;
        stall_left = recv_sparse ? $urandom_range(0, 6) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

>>> filelist.f
rtl/plti_pkg.sv
rtl/plti_ram.sv
rtl/plti_div.sv
rtl/piecewise_linear_table_interp_unit.sv
tb/testbench.sv
